>>> src/lhp99_pkg.sv
// Shared types, widths and constants for the latency histogram / p99 unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package lhp99_pkg;

    localparam int LAT_W           = 64;
    localparam int SAMPLE_W        = 35;
    localparam int OUT_FIELDS_W    = SAMPLE_W + LAT_W;
    localparam int OUT_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int NUM_BOUND_REGS  = 7;
    localparam int CFG_IDX_W       = 3;

    localparam int NUM_BUCKETS_DEF = 7;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int DIVISOR         = 100;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    // request kinds carried on s_tuser
    localparam logic REQ_REPORT  = 1'b0;
    localparam logic REQ_CONSUME = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_0 = 3'd1;

    typedef logic [LAT_W-1:0] bound_arr_t [NUM_BOUND_REGS];

    localparam bound_arr_t BOUND_RESET = '{
        64'd1000, 64'd10000, 64'd100000, 64'd1000000,
        64'd10000000, 64'd100000000, 64'd1000000000
    };

    // 64-bit add that sticks at all ones
    function automatic logic [LAT_W-1:0] sat_add(input logic [LAT_W-1:0] a,
                                                 input logic [LAT_W-1:0] b);
        logic [LAT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LAT_W] ? '1 : s[LAT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> src/latency_histogram_p99_unit.sv
// Top level of the latency histogram / p99 unit: config registers, sequencer, result register.
// Depends on lhp99_pkg, lhp99_mem and lhp99_div100.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tuser: req_type; s_tdata: latency
//  m_       | out | m_tvalid/m_tready  | m_tdata: sample_count, p99_bound_ns, pad
//  cfg_     | in  | cfg_we             | cfg_addr: register index; cfg_wdata: value
//
// A report that lands in a bucket is read from the counter RAM, then written back in S_UPD;
// a report that is dropped or arrives with the guard off finishes in S_IDLE.
// A consume makes two walks over the buckets through the single RAM read port (sum, then scan),
// with the divide by 100 between them, then the result load; an empty window skips to the load.
// Reset clears the per-bucket valid bits at once; no clearing pass is needed.
// A waiting result holds in m_tdata while reports carry on; only the next consume result waits.
`default_nettype none

module latency_histogram_p99_unit #(
    parameter int NUM_BUCKETS = lhp99_pkg::NUM_BUCKETS_DEF,
    parameter int COUNT_WIDTH = lhp99_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    input  wire logic [lhp99_pkg::LAT_W-1:0]       s_tdata,   // [63:0] latency
    input  wire logic                              s_tuser,   // [0] req_type
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // [34:0] sample_count, [98:35] p99_bound_ns, [103:99] zero
    output      logic [lhp99_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [lhp99_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [lhp99_pkg::LAT_W-1:0]       cfg_wdata
);
    import lhp99_pkg::*;

    localparam int IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CNT_W = $clog2(NUM_BUCKETS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUCKETS - 1);
    localparam logic [CNT_W-1:0] NB       = CNT_W'(NUM_BUCKETS);
    localparam int PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

    typedef enum logic [2:0] {S_IDLE, S_UPD, S_SUM, S_DIV, S_SCAN, S_EMIT} state_t;

    // configuration
    logic       guard_reg;
    bound_arr_t bound_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guard_reg <= 1'b1;
            for (int i = 0; i < NUM_BOUND_REGS; i++)
            begin
                bound_reg[i] <= BOUND_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_GUARD)
            begin
                guard_reg <= cfg_wdata[0];
            end
            else
            begin
                bound_reg[cfg_addr - CFG_BOUND_0] <= cfg_wdata;
            end
        end
    end

    // sequencer state
    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    iss_reg, iss_next;
    logic                proc_vld_reg, proc_vld_next;
    logic [IDX_W-1:0]    proc_idx_reg, proc_idx_next;
    logic [LAT_W-1:0]    samples_reg, samples_next;
    logic [LAT_W-1:0]    rank_reg, rank_next;
    logic [LAT_W-1:0]    cum_reg, cum_next;
    logic                found_reg, found_next;
    logic [LAT_W-1:0]    p99_reg, p99_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0] m_count_reg, m_count_next;
    logic [LAT_W-1:0]    m_bound_reg, m_bound_next;

    // RAM and divider hookup
    logic                   rd_en, wr_en, clr_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [COUNT_WIDTH-1:0] rd_count, wr_data;
    logic                   div_start, div_done;
    logic [LAT_W-1:0]       div_quot;

    // bucket lookup for an incoming report
    logic                   rep_hit;
    logic [IDX_W-1:0]       rep_idx;
    logic [LAT_W-1:0]       cnt64, acc;
    logic                   accept;

    always_comb
    begin
        rep_hit = 1'b0;
        rep_idx = '0;
        for (int i = NUM_BUCKETS - 1; i >= 0; i--)
        begin
            if (s_tdata <= bound_reg[i])
            begin
                rep_hit = 1'b1;
                rep_idx = IDX_W'(i);
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cnt64    = LAT_W'(rd_count);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        iss_next      = iss_reg;
        proc_vld_next = 1'b0;
        proc_idx_next = proc_idx_reg;
        samples_next  = samples_reg;
        rank_next     = rank_reg;
        cum_next      = cum_reg;
        found_next    = found_reg;
        p99_next      = p99_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_count_next  = m_count_reg;
        m_bound_next  = m_bound_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_data       = (&rd_count) ? rd_count : rd_count + COUNT_WIDTH'(1);
        clr_en        = 1'b0;
        div_start     = 1'b0;
        acc           = '0;

        // bucket walk shared by both consume passes
        if ((state_reg == S_SUM) || (state_reg == S_SCAN))
        begin
            if (iss_reg < NB)
            begin
                rd_en         = 1'b1;
                rd_addr       = iss_reg[IDX_W-1:0];
                iss_next      = iss_reg + CNT_W'(1);
                proc_vld_next = 1'b1;
                proc_idx_next = iss_reg[IDX_W-1:0];
                clr_en        = (state_reg == S_SCAN);
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == REQ_REPORT)
                    begin
                        if (guard_reg && rep_hit)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = rep_idx;
                            idx_next   = rep_idx;
                            state_next = S_UPD;
                        end
                    end
                    else
                    begin
                        iss_next     = '0;
                        samples_next = '0;
                        state_next   = S_SUM;
                    end
                end
            end
            S_UPD:
            begin
                // no RAM read is issued in this state, so the write needs no forwarding
                wr_en      = 1'b1;
                state_next = S_IDLE;
            end
            S_SUM:
            begin
                if (proc_vld_reg)
                begin
                    acc          = sat_add(samples_reg, cnt64);
                    samples_next = acc;
                    if (proc_idx_reg == LAST_IDX)
                    begin
                        if (acc == '0)
                        begin
                            p99_next   = '0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    rank_next  = samples_reg - div_quot;
                    cum_next   = '0;
                    found_next = 1'b0;
                    p99_next   = '1;
                    iss_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (proc_vld_reg)
                begin
                    acc      = sat_add(cum_reg, cnt64);
                    cum_next = acc;
                    if (!found_reg && (acc >= rank_reg))
                    begin
                        found_next = 1'b1;
                        p99_next   = bound_reg[proc_idx_reg];
                    end
                    if (proc_idx_reg == LAST_IDX)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_count_next  = (samples_reg > LAT_W'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                                       : samples_reg[SAMPLE_W-1:0];
                    m_bound_next  = p99_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            iss_reg      <= '0;
            proc_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            iss_reg      <= iss_next;
            proc_vld_reg <= proc_vld_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        proc_idx_reg <= proc_idx_next;
        samples_reg  <= samples_next;
        rank_reg     <= rank_next;
        cum_reg      <= cum_next;
        p99_reg      <= p99_next;
        m_count_reg  <= m_count_next;
        m_bound_reg  <= m_bound_next;
    end

    lhp99_mem #(
        .DEPTH (NUM_BUCKETS),
        .WIDTH (COUNT_WIDTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_count (rd_count),
        .wr_en    (wr_en),
        .wr_addr  (idx_reg),
        .wr_data  (wr_data),
        .clr_en   (clr_en),
        .clr_addr (rd_addr)
    );

    lhp99_div100 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (samples_next),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {PAD_W'(0), m_bound_reg, m_count_reg};

endmodule

`default_nettype wire

>>> src/lhp99_mem.sv
// Bucket counter store: one synchronous RAM, one read and one write port.
// Per-entry valid bits give the all-zero reset and the clear-on-consume.
// Depends on lhp99_pkg.
`default_nettype none

module lhp99_mem #(
    parameter int DEPTH = lhp99_pkg::NUM_BUCKETS_DEF,
    parameter int WIDTH = lhp99_pkg::COUNT_WIDTH_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output      logic [WIDTH-1:0] rd_count,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             clr_en,
    input  wire logic [IDX_W-1:0] clr_addr
);
    import lhp99_pkg::*;

    logic [WIDTH-1:0] count_mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            count_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= count_mem[rd_addr];
        end
    end

    // valid bit is sampled with the read so a same-edge clear is not seen
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_hit_reg <= vld_reg[rd_addr];
            end
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (clr_en)
            begin
                vld_reg[clr_addr] <= 1'b0;
            end
        end
    end

    assign rd_count = rd_hit_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> src/lhp99_div100.sv
// Divide by the constant 100 as a reciprocal multiply, one 32x32 partial product a cycle.
// Depends on lhp99_pkg.
`default_nettype none

module lhp99_div100 (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [lhp99_pkg::LAT_W-1:0] dividend,
    output      logic                       done,
    output      logic [lhp99_pkg::LAT_W-1:0] quotient
);
    import lhp99_pkg::*;

    localparam int HALF_W  = LAT_W / 2;
    localparam int PROD_W  = 2 * LAT_W;
    // ceil(2^66 / 25): ((x >> 2) * RECIP) >> 66 is x / 100 for every 64-bit x
    localparam logic [LAT_W-1:0] RECIP = 64'h28F5_C28F_5C28_F5C3;
    localparam int Q_SHIFT = 66;
    localparam logic [2:0] STEPS = 3'd4;

    logic [LAT_W-1:0]  y_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [2:0]        cnt_reg;
    logic              done_reg;
    logic [HALF_W-1:0] op_a;
    logic [HALF_W-1:0] op_b;
    logic [LAT_W-1:0]  prod;
    logic [PROD_W-1:0] term;

    // steps 4..1: lo*lo, lo*hi, hi*lo, hi*hi
    assign op_a = (cnt_reg < 3'd3) ? y_reg[LAT_W-1:HALF_W] : y_reg[HALF_W-1:0];
    assign op_b = cnt_reg[0] ? RECIP[LAT_W-1:HALF_W] : RECIP[HALF_W-1:0];
    assign prod = LAT_W'(op_a) * LAT_W'(op_b);
    assign term = (cnt_reg == STEPS) ? {{LAT_W{1'b0}}, prod} :
                  (cnt_reg == 3'd1)  ? {prod, {LAT_W{1'b0}}} :
                                       {{HALF_W{1'b0}}, prod, {HALF_W{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == 3'd1);
            if (start)
            begin
                cnt_reg <= STEPS;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            y_reg   <= {2'b00, dividend[LAT_W-1:2]};
            acc_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= acc_reg + term;
        end
    end

    assign done     = done_reg;
    assign quotient = {2'b00, acc_reg[PROD_W-1:Q_SHIFT]};

endmodule

`default_nettype wire

>>> src/lhp99_checker.sv
// Port-level checks for latency_histogram_p99_unit, attached by bind.
// Depends on lhp99_pkg.
`default_nettype none

module lhp99_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              s_tuser,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [lhp99_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import lhp99_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] == '0))
        else $error("padding bits of m_tdata not zero");

    // empty window reports a zero bound
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[SAMPLE_W-1:0] == '0)) |-> (m_tdata[OUT_FIELDS_W-1:SAMPLE_W] == '0))
        else $error("empty window with non-zero bound");

    a_report_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_REPORT) && !m_tvalid) |=> !m_tvalid)
        else $error("report produced a result beat");

    a_consume_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_CONSUME)) |=> !s_tready)
        else $error("input taken while a consume is in progress");

endmodule

bind latency_histogram_p99_unit lhp99_checker u_lhp99_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
